// ===== sv/abff_pkg.sv =====
// Shared types and constants of the allocation bitmap.
`default_nettype none

package abff_pkg;

  localparam int COUNT_W     = 13;
  localparam int TYPE_W      = 3;
  localparam int INDEX_W     = 12;
  localparam int RECIP_SHIFT = 20;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

  typedef enum logic [TYPE_W-1:0] {
    REQ_SET_BIT    = 3'd0,
    REQ_CLEAR_BIT  = 3'd1,
    REQ_SET_ALL    = 3'd2,
    REQ_CLEAR_ALL  = 3'd3,
    REQ_FIND_SET   = 3'd4,
    REQ_FIND_CLEAR = 3'd5
  } req_code_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [TYPE_W-1:0]  req_type;
    logic [INDEX_W-1:0] block_index;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] found_index;
    logic               all_set;
    logic               all_clear;
  } res_t;

  typedef logic [COUNT_W-1:0] cfg_t;

  // Update of the per-word summary flags, applied on commit.
  typedef struct packed {
    logic fill_en;
    logic fill_val;
    logic wr_en;
    logic wr_has_set;
    logic wr_has_clear;
  } sum_upd_t;

endpackage

`default_nettype wire

// ===== sv/abff_chan_if.sv =====
// Valid/ready channel carrying one payload item.
`default_nettype none

interface abff_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/abff_map_mem.sv =====
// Bitmap word memory: one write port, two registered read ports.
`default_nettype none

module abff_map_mem #(
  parameter int WORD_BITS = 64,
  parameter int MAP_WORDS = 64,
  parameter int AW        = 6
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WORD_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr_a,
  input  logic [AW-1:0]        raddr_b,
  output logic [WORD_BITS-1:0] rdata_a,
  output logic [WORD_BITS-1:0] rdata_b
);

  logic [WORD_BITS-1:0] mem [MAP_WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

// ===== sv/abff_summary.sv =====
// Per-word summary flags, word valid bits and first-word search.
`default_nettype none

module abff_summary import abff_pkg::*; #(
  parameter int MAP_WORDS = 64,
  parameter int AW        = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 commit,
  input  sum_upd_t             upd,
  input  logic [AW-1:0]        wr_addr,
  input  logic                 in_use,
  input  logic [AW-1:0]        last_word,
  output logic [MAP_WORDS-1:0] word_valid,
  output logic                 fill,
  output logic                 cand_set_any,
  output logic [AW-1:0]        cand_set_word,
  output logic                 cand_clear_any,
  output logic [AW-1:0]        cand_clear_word,
  output logic                 below_set_nx,
  output logic                 below_clear_nx
);

  logic [MAP_WORDS-1:0] has_set;
  logic [MAP_WORDS-1:0] has_clear;
  logic [MAP_WORDS-1:0] has_set_next;
  logic [MAP_WORDS-1:0] has_clear_next;
  logic [MAP_WORDS-1:0] word_valid_next;
  logic [MAP_WORDS-1:0] below_mask;
  logic                 fill_next;

  // Flags as they stand after the pending update.
  always_comb begin
    has_set_next    = upd.fill_en ? {MAP_WORDS{upd.fill_val}} : has_set;
    has_clear_next  = upd.fill_en ? {MAP_WORDS{!upd.fill_val}} : has_clear;
    word_valid_next = upd.fill_en ? '0 : word_valid;
    fill_next       = upd.fill_en ? upd.fill_val : fill;
    if (upd.wr_en) begin
      has_set_next[wr_addr]    = upd.wr_has_set;
      has_clear_next[wr_addr]  = upd.wr_has_clear;
      word_valid_next[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      has_set    <= '1;
      has_clear  <= '0;
      word_valid <= '0;
      fill       <= 1'b1;
    end else if (commit) begin
      has_set    <= has_set_next;
      has_clear  <= has_clear_next;
      word_valid <= word_valid_next;
      fill       <= fill_next;
    end
  end

  // Lowest word in use holding a set bit or a clear bit.
  always_comb begin
    cand_set_any    = 1'b0;
    cand_set_word   = '0;
    cand_clear_any  = 1'b0;
    cand_clear_word = '0;
    for (int w = MAP_WORDS - 1; w >= 0; w--) begin
      if (in_use && (w <= int'(last_word))) begin
        if (has_set[w]) begin
          cand_set_any  = 1'b1;
          cand_set_word = AW'(w);
        end
        if (has_clear[w]) begin
          cand_clear_any  = 1'b1;
          cand_clear_word = AW'(w);
        end
      end
    end
  end

  // Words wholly below the last word in use.
  always_comb begin
    for (int w = 0; w < MAP_WORDS; w++) begin
      below_mask[w] = (w < int'(last_word));
    end
  end

  assign below_set_nx   = |(has_set_next & below_mask);
  assign below_clear_nx = |(has_clear_next & below_mask);

endmodule

`default_nettype wire

// ===== sv/allocation_bitmap_find_first.sv =====
// Top level of the free-block bitmap with find-first search.
`default_nettype none

// Free-block bitmap with find-first-set and find-first-clear. The map lives
// in a memory of MAP_WORDS words of WORD_BITS bits; a one marks a free block.
// Every request gives exactly one result item. In the accept cycle the word
// to touch is chosen (from block_index, or from the
// per-word summary flags for a find) and both memory read ports are started,
// one on that word and one on the last word in use; in the execute cycle the
// word is modified and written back, the find bit is priority-encoded and the
// result register is loaded. The next item is taken in the cycle after, so
// a new item is not accepted before the last one is through execute, and
// the execute cycle is held for as long as the result register
// stays full. Set-all, clear-all and reset take effect at once through
// per-word valid bits and a fill value, so there is no clearing pass. After
// reset and after each block_count write, the derive_a and then the derive_b
// register recompute the last word and tail mask in use; no item is accepted meanwhile.
module allocation_bitmap_find_first import abff_pkg::*; #(
  parameter int WORD_BITS = 64,
  parameter int MAP_WORDS = 64
) (
  input  logic              clk,
  input  logic              rst,
  abff_chan_if.sink         req,
  abff_chan_if.source       res,
  abff_chan_if.sink         cfg
);

  localparam int AW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BW       = $clog2(WORD_BITS);
  localparam int CAPACITY = WORD_BITS * MAP_WORDS;
  localparam int RECIP    = ((2 ** RECIP_SHIFT) + WORD_BITS - 1) / WORD_BITS;

  // Floor division by the word size through a reciprocal; exact for 13 bits.
  function automatic logic [COUNT_W-1:0] word_div(input logic [COUNT_W-1:0] x);
    logic [31:0] prod;
    prod = 32'(x) * 32'(RECIP);
    return COUNT_W'(prod >> RECIP_SHIFT);
  endfunction

  state_t state;
  state_t state_next;

  // Configuration and values derived from it.
  logic [COUNT_W-1:0]   block_count;
  logic                 derive_a;
  logic                 derive_b;
  logic [COUNT_W-1:0]   n_clamp;
  logic [COUNT_W-1:0]   nm1_c;
  logic [COUNT_W-1:0]   n_act;
  logic                 n_zero;
  logic [COUNT_W-1:0]   der_nm1;
  logic [COUNT_W-1:0]   der_q;
  logic [BW-1:0]        tail_rem;
  logic [AW-1:0]        last_word;
  logic [WORD_BITS-1:0] tail_mask;

  // Accept cycle.
  logic                 in_fire;
  logic                 cfg_fire;
  logic [COUNT_W-1:0]   idx_word_c;
  logic                 hit_c;
  logic [AW-1:0]        rd_addr_c;
  logic                 cand_any_c;
  logic [TYPE_W-1:0]    op;
  logic [INDEX_W-1:0]   idx;
  logic                 hit;
  logic [AW-1:0]        addr;
  logic                 cand_any;

  // Execute cycle.
  logic                 advance;
  logic                 exec_done;
  logic [WORD_BITS-1:0] rd_a;
  logic [WORD_BITS-1:0] rd_b;
  logic [WORD_BITS-1:0] fill_word;
  logic [WORD_BITS-1:0] word_a;
  logic [WORD_BITS-1:0] word_t;
  logic [BW-1:0]        bit_rem;
  logic [WORD_BITS-1:0] bit_sel;
  logic [WORD_BITS-1:0] new_word;
  logic [WORD_BITS-1:0] look;
  logic [WORD_BITS-1:0] tail_next;
  logic                 lo_any;
  logic [BW-1:0]        lo_bit;
  logic                 wr_en_c;
  logic                 mem_we;
  sum_upd_t             upd;
  logic                 tail_any_set;
  logic                 tail_any_clear;
  res_t                 res_c;
  res_t                 res_q;
  logic                 res_valid;

  // Summary outputs.
  logic [MAP_WORDS-1:0] word_valid;
  logic                 fill;
  logic                 cand_set_any;
  logic [AW-1:0]        cand_set_word;
  logic                 cand_clear_any;
  logic [AW-1:0]        cand_clear_word;
  logic                 below_set_nx;
  logic                 below_clear_nx;

  assign in_fire  = req.valid && req.ready;
  assign cfg_fire = cfg.valid && cfg.ready;
  assign advance  = !res_valid || res.ready;

  // ---------------------------------------------------------------------
  // Configuration: hold block_count, then derive the last word in use and
  // the mask of live bits within it, registered under derive_a, then derive_b.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= COUNT_RESET;
      derive_a    <= 1'b1;
      derive_b    <= 1'b0;
    end else begin
      if (cfg_fire) begin
        block_count <= cfg.data;
      end
      derive_a <= cfg_fire;
      derive_b <= derive_a;
    end
  end

  always_comb begin
    n_clamp = (32'(block_count) > CAPACITY) ? COUNT_W'(CAPACITY) : block_count;
    nm1_c   = (n_clamp == '0) ? '0 : n_clamp - COUNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (derive_a) begin
      n_act   <= n_clamp;
      n_zero  <= (n_clamp == '0);
      der_nm1 <= nm1_c;
      der_q   <= word_div(nm1_c);
    end
  end

  assign tail_rem = BW'(32'(der_nm1) - (32'(der_q) * 32'(WORD_BITS)));

  always_ff @(posedge clk) begin
    if (derive_b) begin
      last_word <= AW'(der_q);
      for (int b = 0; b < WORD_BITS; b++) begin
        tail_mask[b] <= (b <= int'(tail_rem));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (advance) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = (state == ST_IDLE) && !derive_a && !derive_b && !cfg.valid;
    cfg.ready = 1'b1;
    exec_done = (state == ST_EXEC) && advance;
  end

  // ---------------------------------------------------------------------
  // Accept cycle: pick the word and start the reads.
  // ---------------------------------------------------------------------
  always_comb begin
    idx_word_c = word_div({1'b0, req.data.block_index});
    hit_c      = !n_zero && ({1'b0, req.data.block_index} < n_act);
    rd_addr_c  = '0;
    cand_any_c = 1'b0;
    unique case (req.data.req_type)
      REQ_SET_BIT, REQ_CLEAR_BIT: begin
        rd_addr_c = hit_c ? AW'(idx_word_c) : '0;
      end
      REQ_FIND_SET: begin
        rd_addr_c  = cand_set_word;
        cand_any_c = cand_set_any;
      end
      REQ_FIND_CLEAR: begin
        rd_addr_c  = cand_clear_word;
        cand_any_c = cand_clear_any;
      end
      default: begin
        rd_addr_c = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op       <= req.data.req_type;
      idx      <= req.data.block_index;
      hit      <= hit_c;
      addr     <= rd_addr_c;
      cand_any <= cand_any_c;
    end
  end

  // ---------------------------------------------------------------------
  // Execute cycle: modify and write back, search the word, build flags.
  // ---------------------------------------------------------------------
  always_comb begin
    fill_word = {WORD_BITS{fill}};
    word_a    = word_valid[addr] ? rd_a : fill_word;
    word_t    = word_valid[last_word] ? rd_b : fill_word;
    bit_rem   = BW'(32'(idx) - (32'(addr) * 32'(WORD_BITS)));
    bit_sel   = WORD_BITS'(1) << bit_rem;
    new_word  = word_a;
    wr_en_c   = 1'b0;
    upd       = '0;
    unique case (op)
      REQ_SET_BIT: begin
        new_word = word_a | bit_sel;
        wr_en_c  = hit;
      end
      REQ_CLEAR_BIT: begin
        new_word = word_a & ~bit_sel;
        wr_en_c  = hit;
      end
      REQ_SET_ALL: begin
        upd.fill_en  = 1'b1;
        upd.fill_val = 1'b1;
      end
      REQ_CLEAR_ALL: begin
        upd.fill_en  = 1'b1;
        upd.fill_val = 1'b0;
      end
      default: begin
        wr_en_c = 1'b0;
      end
    endcase
    upd.wr_en        = wr_en_c;
    upd.wr_has_set   = |new_word;
    upd.wr_has_clear = ~&new_word;
  end

  // Lowest matching bit of the candidate word, trimmed to the tail if it is
  // the last word in use.
  always_comb begin
    look   = ((op == REQ_FIND_SET) ? word_a : ~word_a)
           & ((addr == last_word) ? tail_mask : {WORD_BITS{1'b1}});
    lo_any = 1'b0;
    lo_bit = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (look[b]) begin
        lo_any = 1'b1;
        lo_bit = BW'(b);
      end
    end
  end

  always_comb begin
    if (upd.fill_en) begin
      tail_next = {WORD_BITS{upd.fill_val}};
    end else if (wr_en_c && (addr == last_word)) begin
      tail_next = new_word;
    end else begin
      tail_next = word_t;
    end
    tail_any_set   = |(tail_next & tail_mask);
    tail_any_clear = |(~tail_next & tail_mask);

    res_c.found       = cand_any && lo_any;
    res_c.found_index = res_c.found
                      ? INDEX_W'((32'(addr) * 32'(WORD_BITS)) + 32'(lo_bit))
                      : '0;
    res_c.all_set     = n_zero || (!below_clear_nx && !tail_any_clear);
    res_c.all_clear   = n_zero || (!below_set_nx && !tail_any_set);
  end

  assign mem_we = exec_done && wr_en_c;

  abff_map_mem #(
    .WORD_BITS (WORD_BITS),
    .MAP_WORDS (MAP_WORDS),
    .AW        (AW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (addr),
    .wdata   (new_word),
    .re      (in_fire),
    .raddr_a (rd_addr_c),
    .raddr_b (last_word),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  abff_summary #(
    .MAP_WORDS (MAP_WORDS),
    .AW        (AW)
  ) u_summary (
    .clk             (clk),
    .rst             (rst),
    .commit          (exec_done),
    .upd             (upd),
    .wr_addr         (addr),
    .in_use          (!n_zero),
    .last_word       (last_word),
    .word_valid      (word_valid),
    .fill            (fill),
    .cand_set_any    (cand_set_any),
    .cand_set_word   (cand_set_word),
    .cand_clear_any  (cand_clear_any),
    .cand_clear_word (cand_clear_word),
    .below_set_nx    (below_set_nx),
    .below_clear_nx  (below_clear_nx)
  );

  // ---------------------------------------------------------------------
  // Result register: hold the item until the sink takes it.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (exec_done) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_done) begin
      res_q <= res_c;
    end
  end

  assign res.valid = res_valid;
  assign res.data  = res_q;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  a_fire_to_exec: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == ST_EXEC))
    else $error("accepted item did not enter execute");

  a_no_accept_derive: assert property (@(posedge clk) disable iff (rst)
    (derive_a || derive_b) |-> !req.ready)
    else $error("item accepted while count derivation runs");

  a_write_in_use: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (addr <= last_word) && !n_zero)
    else $error("map write outside the words in use");

  a_found_in_range: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_q.found) |-> ({1'b0, res_q.found_index} < n_act))
    else $error("found index at or above block count");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_q.all_set && res_q.all_clear) |-> n_zero)
    else $error("all set and all clear with blocks in use");

endmodule

`default_nettype wire

// ===== tb/sv/allocation_bitmap_find_first_tb.sv =====
// Self-checking testbench of the free-block bitmap with find-first search.
module allocation_bitmap_find_first_tb;
  import abff_pkg::*;

  localparam int WORD_BITS    = 64;
  localparam int MAP_WORDS    = 64;
  localparam int CAPACITY     = WORD_BITS * MAP_WORDS;
  localparam int RANDOM_ITEMS = 1500;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;
  localparam int LONG_HOLD    = 300;

  // Request codes the block has no operation for; they must change nothing.
  localparam logic [TYPE_W-1:0] REQ_SPARE_6 = 3'd6;
  localparam logic [TYPE_W-1:0] REQ_SPARE_7 = 3'd7;

  // One entry of the stimulus plan: a request item, a block_count write,
  // or a pause until every outstanding result has come back.
  typedef enum {STEP_ITEM, STEP_COUNT, STEP_DRAIN} step_kind_t;
  typedef struct {
    step_kind_t kind;
    req_t       item;
    cfg_t       count;
  } step_t;

  logic clk;
  logic rst;

  abff_chan_if #(.T(req_t)) req_if ();
  abff_chan_if #(.T(res_t)) res_if ();
  abff_chan_if #(.T(cfg_t)) cfg_if ();

  allocation_bitmap_find_first #(
    .WORD_BITS(WORD_BITS),
    .MAP_WORDS(MAP_WORDS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .res(res_if),
    .cfg(cfg_if)
  );

  // Mirror of the bitmap and the block count, advanced at each handshake.
  bit [CAPACITY-1:0] free_blocks;
  cfg_t              block_limit;
  res_t              expected_q[$];
  int unsigned       mismatches;

  // Stimulus plan, filled up front and consumed by the request driver.
  step_t       plan_q[$];
  int unsigned plan_n;
  int unsigned alloc_mark;

  // Driver and receiver bookkeeping.
  int          in_flight;
  int unsigned gap_left;
  bit          tx_calm;
  int unsigned stall_left;
  int unsigned hold_left;
  int unsigned results_taken;
  int unsigned next_hold_at;
  bit          rx_calm;
  int unsigned cycles;

  // ---------------------------------------------------------------------
  // Predictor: apply one request to the mirrored map and return the result
  // the block owes for it.
  // ---------------------------------------------------------------------
  function automatic res_t apply_request(req_t r);
    res_t        o;
    int unsigned n;
    int unsigned i;
    bit          want;
    bit          seen_set;
    bit          seen_clear;
    // Counts beyond the map size clip to the map size.
    n          = (block_limit > CAPACITY) ? CAPACITY : block_limit;
    o          = '0;
    seen_set   = 1'b0;
    seen_clear = 1'b0;
    case (r.req_type)
      REQ_SET_BIT: begin
        if (r.block_index < n) free_blocks[r.block_index] = 1'b1;
      end
      REQ_CLEAR_BIT: begin
        if (r.block_index < n) free_blocks[r.block_index] = 1'b0;
      end
      // Fills touch the whole map, also bits above the count in use.
      REQ_SET_ALL:   free_blocks = '1;
      REQ_CLEAR_ALL: free_blocks = '0;
      REQ_FIND_SET, REQ_FIND_CLEAR: begin
        want = (r.req_type == REQ_FIND_SET);
        for (i = 0; i < n && !o.found; i++) begin
          if (free_blocks[i] == want) begin
            o.found       = 1'b1;
            o.found_index = INDEX_W'(i);
          end
        end
      end
      default: ;
    endcase
    // Summary flags look only at bits in use; with no bits both are high.
    for (i = 0; i < n; i++) begin
      if (free_blocks[i]) seen_set = 1'b1;
      else seen_clear = 1'b1;
    end
    o.all_set   = !seen_clear;
    o.all_clear = !seen_set;
    return o;
  endfunction

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_gap(bit calm);
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(string why, res_t want, res_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t mismatch (%s): expected found=%0d index=%0d set=%0d clear=%0d",
               $realtime, why, want.found, want.found_index, want.all_set,
               want.all_clear);
    if (mismatches <= MAX_REPORTS)
      $display("%0t   actual: found=%0d index=%0d set=%0d clear=%0d",
               $realtime, got.found, got.found_index, got.all_set, got.all_clear);
  endtask

  // ---------------------------------------------------------------------
  // Plan building.
  // ---------------------------------------------------------------------
  task automatic plan_item(logic [TYPE_W-1:0] code, int unsigned idx);
    step_t s;
    s.kind             = STEP_ITEM;
    s.item.req_type    = code;
    s.item.block_index = INDEX_W'(idx);
    s.count            = '0;
    plan_q.push_back(s);
  endtask

  task automatic plan_count(cfg_t value);
    step_t s;
    s.kind  = STEP_COUNT;
    s.item  = '0;
    s.count = value;
    plan_q.push_back(s);
    plan_n     = (value > CAPACITY) ? CAPACITY : value;
    alloc_mark = 0;
  endtask

  task automatic plan_drain();
    step_t s;
    s.kind  = STEP_DRAIN;
    s.item  = '0;
    s.count = '0;
    plan_q.push_back(s);
  endtask

  // Block index: mostly within the count, some at its edge, some at the
  // extremes of the field, a few anywhere.
  function automatic int unsigned pick_index();
    int unsigned roll;
    int unsigned v;
    roll = $urandom_range(0, 99);
    if (plan_n > 0 && roll < 70) return $urandom_range(0, plan_n - 1);
    if (roll < 82) begin
      v = plan_n + $urandom_range(0, 3);
      v = (v >= 2) ? v - 2 : v;
      return (v > CAPACITY - 1) ? CAPACITY - 1 : v;
    end
    if (roll < 90) return $urandom_range(0, 1) ? 0 : CAPACITY - 1;
    return $urandom_range(0, CAPACITY - 1);
  endfunction

  // Run of consecutive sets or clears followed by a find. Half the runs
  // allocate upward from a moving mark, the way an allocator fills the map,
  // so finds land deep in the map and across word boundaries.
  task automatic plan_run();
    int unsigned start;
    int unsigned len;
    int unsigned k;
    logic [TYPE_W-1:0] code;
    len = $urandom_range(1, 70);
    if ($urandom_range(0, 1) && plan_n > 0) begin
      code  = REQ_CLEAR_BIT;
      start = alloc_mark;
      alloc_mark = (alloc_mark + len >= plan_n) ? 0 : alloc_mark + len;
    end else begin
      code  = $urandom_range(0, 1) ? REQ_SET_BIT : REQ_CLEAR_BIT;
      start = pick_index();
    end
    for (k = 0; k < len; k++) plan_item(code, (start + k) % CAPACITY);
    plan_item($urandom_range(0, 1) ? REQ_FIND_SET : REQ_FIND_CLEAR,
              $urandom_range(0, CAPACITY - 1));
  endtask

  task automatic plan_random_item();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 30)      plan_item(REQ_CLEAR_BIT, pick_index());
    else if (roll < 52) plan_item(REQ_SET_BIT, pick_index());
    else if (roll < 67) plan_item(REQ_FIND_SET, $urandom_range(0, CAPACITY - 1));
    else if (roll < 82) plan_item(REQ_FIND_CLEAR, $urandom_range(0, CAPACITY - 1));
    else if (roll < 85) begin
      plan_item(REQ_SET_ALL, $urandom_range(0, CAPACITY - 1));
      alloc_mark = 0;
    end
    else if (roll < 88) plan_item(REQ_CLEAR_ALL, $urandom_range(0, CAPACITY - 1));
    else if (roll < 90)
      plan_item(roll[0] ? REQ_SPARE_6 : REQ_SPARE_7, $urandom_range(0, CAPACITY - 1));
    else plan_run();
  endtask

  // ---------------------------------------------------------------------
  // Clock and cycle limit.
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** allocation_bitmap_find_first: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Request and configuration driver. Take the head of the plan; hold an
  // offered item until it is accepted; issue a count write or a drain only
  // once every result is back.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : drive_requests
    logic nv;
    req_t nd;
    logic ncv;
    cfg_t ncd;
    if (rst) begin
      req_if.valid <= 1'b0;
      cfg_if.valid <= 1'b0;
      in_flight = 0;
      gap_left  = 0;
    end else begin
      nv  = req_if.valid;
      nd  = req_if.data;
      ncv = cfg_if.valid;
      ncd = cfg_if.data;
      if (req_if.valid && req_if.ready) begin
        void'(plan_q.pop_front());
        in_flight++;
        nv       = 1'b0;
        gap_left = pick_gap(tx_calm);
      end
      if (res_if.valid && res_if.ready) in_flight--;
      if (cfg_if.valid && cfg_if.ready) begin
        void'(plan_q.pop_front());
        ncv     = 1'b0;
        tx_calm = ($urandom_range(0, 3) == 0);
      end
      // Pick up the next step; a back-to-back item keeps valid high.
      if (!nv && !ncv && plan_q.size() > 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          case (plan_q[0].kind)
            STEP_ITEM: begin
              nv = 1'b1;
              nd = plan_q[0].item;
            end
            STEP_COUNT: begin
              if (in_flight == 0) begin
                ncv = 1'b1;
                ncd = plan_q[0].count;
              end
            end
            STEP_DRAIN: begin
              if (in_flight == 0) begin
                void'(plan_q.pop_front());
                tx_calm = ($urandom_range(0, 3) == 0);
              end
            end
          endcase
        end
      end
      req_if.valid <= nv;
      req_if.data  <= nd;
      cfg_if.valid <= ncv;
      cfg_if.data  <= ncd;
    end
  end

  // ---------------------------------------------------------------------
  // Result receiver. Stall at random after each result; now and then hold
  // ready low for a long stretch so the block backs up into its input.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : accept_results
    if (rst) begin
      res_if.ready <= 1'b0;
      stall_left    = 0;
      hold_left     = 0;
      results_taken = 0;
      next_hold_at  = 150;
    end else begin
      if (res_if.valid && res_if.ready) begin
        results_taken++;
        stall_left = pick_gap(rx_calm);
        if (results_taken % 128 == 0) rx_calm = ($urandom_range(0, 3) == 0);
        if (results_taken == next_hold_at) begin
          hold_left    = LONG_HOLD;
          next_hold_at = next_hold_at + 450;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: advance the mirror on count writes and accepted items, then
  // check each accepted result against the oldest expectation.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    res_t  want;
    res_t  got;
    string bad;
    if (rst) begin
      free_blocks = '1;
      block_limit = COUNT_RESET;
      expected_q.delete();
    end else begin
      if (cfg_if.valid && cfg_if.ready) block_limit = cfg_if.data;
      if (req_if.valid && req_if.ready) expected_q.push_back(apply_request(req_if.data));
      if (res_if.valid && res_if.ready) begin
        got = res_if.data;
        if (expected_q.size() == 0) begin
          report_mismatch("no item expected", '0, got);
        end else begin
          want = expected_q.pop_front();
          bad  = "";
          if (got.found !== want.found)             bad = {bad, " found"};
          if (got.found_index !== want.found_index) bad = {bad, " found_index"};
          if (got.all_set !== want.all_set)         bad = {bad, " all_set"};
          if (got.all_clear !== want.all_clear)     bad = {bad, " all_clear"};
          if (bad != "") report_mismatch(bad, want, got);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus plan, reset and end of run.
  // ---------------------------------------------------------------------
  initial begin
    int unsigned base;
    int unsigned phase;
    int unsigned len;
    rst           = 1'b1;
    req_if.valid  = 1'b0;
    req_if.data   = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    res_if.ready  = 1'b0;
    mismatches    = 0;
    cycles        = 0;
    tx_calm       = 1'b0;
    rx_calm       = 1'b0;
    alloc_mark    = 0;
    plan_n        = CAPACITY;

    // Directed part at the reset count: finds on a full and an empty map,
    // both ends of the index range, fills, and the spare codes.
    plan_item(REQ_FIND_SET, 0);
    plan_item(REQ_FIND_CLEAR, CAPACITY - 1);
    plan_item(REQ_CLEAR_BIT, 0);
    plan_item(REQ_CLEAR_BIT, CAPACITY - 1);
    plan_item(REQ_FIND_CLEAR, 0);
    plan_item(REQ_FIND_SET, 0);
    plan_item(REQ_CLEAR_ALL, 0);
    plan_item(REQ_FIND_SET, 0);
    plan_item(REQ_SET_BIT, CAPACITY - 1);
    plan_item(REQ_FIND_SET, 0);
    plan_item(REQ_SET_ALL, 0);
    plan_item(REQ_SPARE_6, CAPACITY - 1);
    plan_item(REQ_SPARE_7, 0);
    // Count of zero: finds fail, both flags high, a clear does nothing.
    plan_count(cfg_t'(0));
    plan_item(REQ_FIND_SET, 0);
    plan_item(REQ_CLEAR_BIT, 0);
    plan_item(REQ_FIND_CLEAR, 0);
    // Count beyond the map size clips to the map size.
    plan_count(cfg_t'(8191));
    plan_item(REQ_CLEAR_BIT, CAPACITY - 1);
    plan_item(REQ_FIND_CLEAR, 0);
    // One block: an index at the count is ignored.
    plan_count(cfg_t'(1));
    plan_item(REQ_CLEAR_BIT, 1);
    plan_item(REQ_CLEAR_BIT, 0);
    plan_item(REQ_FIND_CLEAR, 0);
    // Bits above the count stay out of the flags.
    plan_count(cfg_t'(100));
    plan_item(REQ_CLEAR_BIT, 100);
    plan_item(REQ_FIND_CLEAR, 0);
    plan_item(REQ_SET_BIT, 0);
    plan_drain();

    // Random phases, each under its own block count.
    base  = plan_q.size();
    phase = 0;
    while (plan_q.size() - base < RANDOM_ITEMS) begin
      case (phase % 10)
        0: plan_count(cfg_t'(CAPACITY));
        1: plan_count(cfg_t'(1));
        2: plan_count(cfg_t'(WORD_BITS));
        3: plan_count(cfg_t'(WORD_BITS + 1));
        4: plan_count(cfg_t'(8191));
        5: plan_count(cfg_t'(0));
        6: plan_count(cfg_t'(CAPACITY - 1));
        7: plan_count(cfg_t'(2 * WORD_BITS - 1));
        default: plan_count(cfg_t'($urandom_range(1, CAPACITY)));
      endcase
      phase++;
      len = (plan_n == 0) ? 5 : $urandom_range(15, 50);
      repeat (len) plan_random_item();
      if (phase % 3 == 0) plan_drain();
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Wait for the plan to empty and every result to return, then settle.
    do @(negedge clk); while (plan_q.size() != 0 || in_flight != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("** allocation_bitmap_find_first: PASSED **");
    end else begin
      $display("** allocation_bitmap_find_first: FAILED **");
    end
    $finish;
  end

endmodule
